/* sv/rsm_pkg.sv */
// rsm_pkg: types, constants and the exponential table for row_softmax
// no dependencies
`timescale 1ns / 1ps

package rsm_pkg;

  typedef struct packed {
    logic signed [15:0] score;
    logic               masked;
    logic               row_end;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] prob;
    logic        last_of_row;
    logic        row_overflow;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SUM_RD,
    ST_SUM,
    ST_NORM_RD,
    ST_EXP,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr_row;
    logic load;
    logic rd_first;
    logic rd_next;
    logic acc_sum;
    logic calc_exp;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_elem;
    logic div_done;
  } stat_t;

  localparam int SumW = 23;
  localparam int ExpW = 16;

  function automatic logic [15:0] exp_lut(input logic [3:0] idx);
    logic [15:0] r;
    case (idx)
      4'd0:  r = 16'd65535;
      4'd1:  r = 16'd62757;
      4'd2:  r = 16'd60096;
      4'd3:  r = 16'd57549;
      4'd4:  r = 16'd55109;
      4'd5:  r = 16'd52773;
      4'd6:  r = 16'd50535;
      4'd7:  r = 16'd48393;
      4'd8:  r = 16'd46341;
      4'd9:  r = 16'd44376;
      4'd10: r = 16'd42495;
      4'd11: r = 16'd40693;
      4'd12: r = 16'd38968;
      4'd13: r = 16'd37316;
      4'd14: r = 16'd35734;
      default: r = 16'd34219;
    endcase
    return r;
  endfunction

endpackage

/* sv/row_softmax.sv */
// row_softmax: top level, joins the sequencer and the datapath
// depends on rsm_pkg, rsm_ctrl, rsm_dp
`timescale 1ns / 1ps

// Max-subtracted softmax over one row of signed Q7.8 scores. Elements come in
// one beat per cycle while busy is low (start high); each is stored with its
// mask flag, and up to ROW_MAX are kept, further ones dropped and flagged.
// The beat with row_end starts the output: after a read of the first entry,
// one pass over the stored row sums exp(score - max) over the unmasked
// elements, then for each element an exp step, a bit-serial divider and an
// emit step form the Q1.15 probability; busy stays high until the last one is
// emitted, so no new row is taken meanwhile. Results come out in arrival
// order with strobe high for one cycle each, the last one in the same cycle
// that busy drops; the receiver cannot stall them.

module row_softmax #(
  parameter int ROW_MAX = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rsm_pkg::in_beat_t   din,
  output logic                busy,
  output logic                strobe,
  output rsm_pkg::out_beat_t  dout
);

  rsm_pkg::cmd_t  cmd;
  rsm_pkg::stat_t stat;

  // sequencer: load, sum pass, normalize pass
  rsm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .row_end (din.row_end),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  // store, max tracking, exp, sum and divider
  rsm_dp #(.ROW_MAX(ROW_MAX)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .din    (din),
    .cmd    (cmd),
    .stat   (stat),
    .strobe (strobe),
    .dout   (dout)
  );

endmodule

/* sv/rsm_ctrl.sv */
// rsm_ctrl: sequencer for load, sum pass and normalize pass
// depends on rsm_pkg
`timescale 1ns / 1ps

module rsm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             row_end,
  input  rsm_pkg::stat_t   stat,
  output logic             busy,
  output rsm_pkg::cmd_t    cmd
);

  rsm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= rsm_pkg::ST_LOAD;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      rsm_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (row_end) state_next = rsm_pkg::ST_SUM_RD;
        end
      end
      rsm_pkg::ST_SUM_RD: begin
        cmd.rd_first = 1'b1;
        state_next = rsm_pkg::ST_SUM;
      end
      rsm_pkg::ST_SUM: begin
        cmd.acc_sum = 1'b1;
        if (stat.last_elem) begin
          state_next = rsm_pkg::ST_NORM_RD;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      rsm_pkg::ST_NORM_RD: begin
        cmd.rd_first = 1'b1;
        state_next = rsm_pkg::ST_EXP;
      end
      rsm_pkg::ST_EXP: begin
        cmd.calc_exp = 1'b1;
        cmd.div_start = 1'b1;
        state_next = rsm_pkg::ST_DIV;
      end
      rsm_pkg::ST_DIV: begin
        if (stat.div_done) state_next = rsm_pkg::ST_EMIT;
      end
      rsm_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.last_elem) begin
          cmd.clr_row = 1'b1;
          state_next = rsm_pkg::ST_LOAD;
        end else begin
          cmd.rd_next = 1'b1;
          state_next = rsm_pkg::ST_EXP;
        end
      end
      default: state_next = rsm_pkg::ST_LOAD;
    endcase
  end

endmodule

/* sv/rsm_dp.sv */
// rsm_dp: row store, running max, exponential, sum and serial divider
// depends on rsm_pkg
`timescale 1ns / 1ps

module rsm_dp #(
  parameter int ROW_MAX = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  rsm_pkg::in_beat_t   din,
  input  rsm_pkg::cmd_t       cmd,
  output rsm_pkg::stat_t      stat,
  output logic                strobe,
  output rsm_pkg::out_beat_t  dout
);

  localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int CW = $clog2(ROW_MAX + 1);

  logic [16:0]        mem [ROW_MAX];
  logic [16:0]        rd_data;
  logic [AW-1:0]      rd_addr;
  logic [CW-1:0]      count;
  logic signed [15:0] running_max;
  logic               any_unmasked;
  logic               overflow_seen;
  logic [rsm_pkg::SumW-1:0] exp_sum;
  logic               exp_ok;

  // exponential of the registered read entry
  logic [16:0] diff;
  logic [24:0] y;
  logic [15:0] e_comb;
  always_comb begin
    diff = {running_max[15], running_max} - {rd_data[15], rd_data[15:0]};
    if (diff[16]) diff = '0;
    y = {9'd0, diff[15:0]} * 25'd369;
    if (y[24:20] != 5'd0) e_comb = '0;
    else e_comb = rsm_pkg::exp_lut(y[15:12]) >> y[19:16];
  end

  logic [AW-1:0] rd_addr_next;
  assign rd_addr_next = cmd.rd_first ? '0 : AW'(rd_addr + 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.load && (count < CW'(ROW_MAX)))
      mem[count[AW-1:0]] <= {din.masked, din.score};
    if (cmd.rd_first || cmd.rd_next) rd_data <= mem[rd_addr_next];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_row) begin
      count <= '0;
      running_max <= 16'sh8000;
      any_unmasked <= 1'b0;
      overflow_seen <= 1'b0;
      rd_addr <= '0;
    end else begin
      if (cmd.load) begin
        if (count < CW'(ROW_MAX)) begin
          count <= count + 1'b1;
          if (!din.masked) begin
            if (!any_unmasked || din.score > running_max) running_max <= din.score;
            any_unmasked <= 1'b1;
          end
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (cmd.rd_first || cmd.rd_next) rd_addr <= rd_addr_next;
    end
  end

  assign stat.last_elem = (CW'(rd_addr) + 1'b1) == count;

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_row) exp_sum <= '0;
    else if (cmd.acc_sum && !rd_data[16])
      exp_sum <= exp_sum + rsm_pkg::SumW'(e_comb);
  end

  // restoring divider: (exp << 15) / exp_sum, one quotient bit per cycle
  localparam int NB = 31;
  logic [NB-1:0]              dvd;
  logic [rsm_pkg::SumW:0]     rem;
  logic [4:0]                 bitcnt;
  logic                       div_run;
  logic [rsm_pkg::SumW:0]     trial;

  assign trial = {rem[rsm_pkg::SumW-1:0], dvd[NB-1]} - {1'b0, exp_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
    end else if (cmd.div_start) begin
      div_run <= 1'b1;
      bitcnt <= 5'(NB - 1);
    end else if (div_run) begin
      if (bitcnt == '0) div_run <= 1'b0;
      bitcnt <= bitcnt - 1'b1;
    end
    if (cmd.calc_exp) begin
      exp_ok <= !rd_data[16] && (exp_sum != '0);
      dvd <= {e_comb, 15'd0};
      rem <= '0;
    end else if (div_run) begin
      if (!trial[rsm_pkg::SumW]) begin
        rem <= trial;
        dvd <= {dvd[NB-2:0], 1'b1};
      end else begin
        rem <= {rem[rsm_pkg::SumW-1:0], dvd[NB-1]};
        dvd <= {dvd[NB-2:0], 1'b0};
      end
    end
  end

  assign stat.div_done = div_run && (bitcnt == '0);

  // output register, one beat per stored element
  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else strobe <= cmd.emit;
    if (cmd.emit) begin
      dout.prob <= exp_ok ? ((dvd > NB'(32768)) ? 16'd32768 : dvd[15:0]) : 16'd0;
      dout.last_of_row <= stat.last_elem;
      dout.row_overflow <= overflow_seen;
    end
  end

  logic unused_ok;
  assign unused_ok = din.row_end;

endmodule

/* bench/tb.sv */
// tb: self-checking bench for row_softmax, directed rows then random rows
// depends on rsm_pkg and row_softmax
`timescale 1ns / 1ps

module tb;

  localparam int RowCap = 64;
  localparam longint CycleLimit = 2000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  rsm_pkg::in_beat_t  din = '0;
  logic               busy;
  logic               strobe;
  rsm_pkg::out_beat_t dout;

  row_softmax #(.ROW_MAX(RowCap)) uut (
    .clk(clk), .rst(rst), .start(start), .din(din),
    .busy(busy), .strobe(strobe), .dout(dout)
  );

  always #6 clk = ~clk;

  // predictor state, mirrors the row held inside the block
  logic signed [15:0] row_scores [RowCap];
  logic               row_masks  [RowCap];
  int                 row_len;
  logic signed [15:0] row_peak;
  logic               row_has_live;
  logic               row_dropped;

  rsm_pkg::out_beat_t prob_queue[$];
  int        fail_count = 0;
  longint    cycle_count = 0;

  // exponential approximation, Q0.16 result
  function automatic logic [16:0] exp_fixed(logic signed [15:0] s, logic signed [15:0] m);
    int d;
    logic [31:0] y;
    logic [31:0] k;
    logic [15:0] base;
    d = int'(m) - int'(s);
    if (d < 0) d = 0;
    y = (d & 32'hFFFF) * 32'd369;
    k = y >> 16;
    case (y[15:12])
      4'd0: base = 16'd65535;  4'd1: base = 16'd62757;
      4'd2: base = 16'd60096;  4'd3: base = 16'd57549;
      4'd4: base = 16'd55109;  4'd5: base = 16'd52773;
      4'd6: base = 16'd50535;  4'd7: base = 16'd48393;
      4'd8: base = 16'd46341;  4'd9: base = 16'd44376;
      4'd10: base = 16'd42495; 4'd11: base = 16'd40693;
      4'd12: base = 16'd38968; 4'd13: base = 16'd37316;
      4'd14: base = 16'd35734; default: base = 16'd34219;
    endcase
    if (k >= 16) return 17'd0;
    return {1'b0, base >> k};
  endfunction

  task automatic clear_prediction();
    row_len = 0;
    row_peak = 16'sh8000;
    row_has_live = 1'b0;
    row_dropped = 1'b0;
  endtask

  // update predictor for one accepted beat, queue the row's results on row_end
  task automatic predict_beat(rsm_pkg::in_beat_t b);
    logic [22:0] total;
    longint p;
    rsm_pkg::out_beat_t r;
    if (row_len < RowCap) begin
      row_scores[row_len] = b.score;
      row_masks[row_len] = b.masked;
      row_len++;
      if (!b.masked) begin
        if (!row_has_live || b.score > row_peak) row_peak = b.score;
        row_has_live = 1'b1;
      end
    end else begin
      row_dropped = 1'b1;
    end
    if (!b.row_end) return;
    total = '0;
    for (int i = 0; i < row_len; i++)
      if (!row_masks[i]) total = total + exp_fixed(row_scores[i], row_peak);
    for (int i = 0; i < row_len; i++) begin
      p = 0;
      if (!row_masks[i] && total != 0) begin
        p = (longint'(exp_fixed(row_scores[i], row_peak)) * 32768) / longint'(total);
        if (p > 32768) p = 32768;
      end
      r.prob = p[15:0];
      r.last_of_row = (i + 1 == row_len);
      r.row_overflow = row_dropped;
      prob_queue.push_back(r);
    end
    clear_prediction();
  endtask

  // send one beat after a random gap, waits for the handshake
  task automatic send_beat(logic signed [15:0] s, logic m, logic e);
    rsm_pkg::in_beat_t b;
    int gap;
    b.score = s; b.masked = m; b.row_end = e;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    din <= b;
    do @(posedge clk); while (busy);
    predict_beat(b);
  endtask

  // random row of n elements, each masked with a chance of mask_pct percent
  task automatic send_row(int n, int mask_pct, int spread);
    logic signed [15:0] s;
    for (int i = 0; i < n; i++) begin
      if (spread == 0) s = 16'($urandom);
      else s = 16'(int'($urandom_range(0, spread)) - spread / 2);
      send_beat(s, $urandom_range(0, 99) < mask_pct, i == n - 1);
    end
  endtask

  task automatic test_extremes();
    send_beat(16'sh7FFF, 1'b0, 1'b0);
    send_beat(16'sh8000, 1'b0, 1'b0);
    send_beat(16'sd0, 1'b0, 1'b1);
    send_beat(16'sd100, 1'b0, 1'b1);          // single element row
    send_beat(16'sd5, 1'b0, 1'b0);
    send_beat(16'sd5, 1'b0, 1'b1);            // equal scores
    send_beat(16'sh7FFF, 1'b1, 1'b0);         // masked ahead of live
    send_beat(-16'sd300, 1'b0, 1'b0);
    send_beat(16'sd256, 1'b0, 1'b1);
  endtask

  task automatic test_all_masked();
    send_beat(16'sh1234, 1'b1, 1'b0);
    send_beat(-16'sd1, 1'b1, 1'b0);
    send_beat(16'sd0, 1'b1, 1'b1);
  endtask

  task automatic test_overflow();
    // capacity row plus dropped beats, the last dropped one ends the row
    for (int i = 0; i < RowCap + 3; i++)
      send_beat(16'($urandom), $urandom_range(0, 7) == 0, i == RowCap + 2);
    // exactly full row, no drop
    send_row(RowCap, 10, 2000);
  endtask

  task automatic test_random();
    int n;
    for (int r = 0; r < 30; r++) begin
      n = $urandom_range(1, 8);
      case ($urandom_range(0, 3))
        0: send_row(n, 20, 0);
        1: send_row(n, 10, 1500);
        2: send_row(n, 60, 400);
        default: send_row(n, 0, 4000);
      endcase
    end
  endtask

  // result checker, strobe cannot be held off
  always @(posedge clk) begin
    rsm_pkg::out_beat_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && strobe) begin
      if (prob_queue.size() == 0) begin
        $error("result beat with nothing expected: prob %0d", dout.prob);
        fail_count = fail_count + 1;
      end else begin
        want = prob_queue.pop_front();
        if (dout.prob !== want.prob) begin
          $error("prob expected %0d actual %0d", want.prob, dout.prob);
          fail_count = fail_count + 1;
        end
        if (dout.last_of_row !== want.last_of_row) begin
          $error("last_of_row expected %0d actual %0d", want.last_of_row, dout.last_of_row);
          fail_count = fail_count + 1;
        end
        if (dout.row_overflow !== want.row_overflow) begin
          $error("row_overflow expected %0d actual %0d",
                 want.row_overflow, dout.row_overflow);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clear_prediction();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_all_masked();
    test_overflow();
    test_random();
    start <= 1'b0;
    while (prob_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && prob_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
